### rtl/core/ps2_mouse_packet_cursor_tracker_core_assert.svh
// assertion macros for the cursor tracker core
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/ps2mct_pkg.sv
package ps2mct_pkg;

   // item modes
   localparam logic MODE_RX_BYTE     = 1'b0;
   localparam logic MODE_SCROLL_READ = 1'b1;

   // controller status and header bit positions
   localparam int STATUS_FULL_BIT = 0;
   localparam int STATUS_AUX_BIT  = 5;
   localparam int HDR_X_SIGN_BIT  = 4;
   localparam int HDR_Y_SIGN_BIT  = 5;

   // register indexes
   localparam logic [3:0] CSR_WHEEL_ENABLE  = 4'd0;
   localparam logic [3:0] CSR_SENSITIVITY   = 4'd1;
   localparam logic [3:0] CSR_SCREEN_WIDTH  = 4'd2;
   localparam logic [3:0] CSR_SCREEN_HEIGHT = 4'd3;

   // reset values
   localparam logic [7:0]  SENS_RESET   = 8'd2;
   localparam logic [12:0] WIDTH_RESET  = 13'd800;
   localparam logic [12:0] HEIGHT_RESET = 13'd600;
   localparam logic [11:0] POS_X_RESET  = 12'd400;
   localparam logic [11:0] POS_Y_RESET  = 12'd300;

   localparam logic [12:0] SCREEN_MAX = 13'd4096;

   // one quotient bit per step over a 9-bit magnitude
   localparam int DIV_STEPS = 9;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic       start;
      logic       neg;
      logic [8:0] mag;
      logic [7:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic signed [9:0] quot;
   } div_rsp_type;

endpackage

### rtl/core/ps2mct_div.sv
module ps2mct_div (
   input  logic                    clock,
   input  logic                    reset,
   input  ps2mct_pkg::div_req_type div_req,
   output ps2mct_pkg::div_rsp_type div_rsp
);

   localparam logic [ps2mct_pkg::DIV_CNT_W-1:0] CNT_LAST =
      ps2mct_pkg::DIV_CNT_W'(ps2mct_pkg::DIV_STEPS - 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic [ps2mct_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [7:0]                        rem_ff;
   logic [8:0]                        dvd_ff;
   logic [8:0]                        quo_ff;
   logic [7:0]                        dsr_ff;
   logic                              neg_ff;
   logic signed [9:0]                 quot_ff;

   logic [8:0]        rem_sh;
   logic              fits;
   logic [7:0]        rem_in;
   logic [8:0]        quo_in;
   logic signed [9:0] quot_in;

   // restoring step: shift in one dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[8]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      rem_in  = fits ? 8'(rem_sh - {1'b0, dsr_ff}) : rem_sh[7:0];
      quo_in  = {quo_ff[7:0], fits};
      quot_in = neg_ff ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         dvd_ff <= div_req.mag;
         quo_ff <= '0;
         dsr_ff <= div_req.divisor;
         neg_ff <= div_req.neg;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[7:0], 1'b0};
         quo_ff <= quo_in;
         if (cnt_ff == CNT_LAST) begin
            quot_ff <= quot_in;
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### rtl/core/ps2_mouse_packet_cursor_tracker_core.sv
// result: a byte that does not finish a packet, or a scroll read, is a result word in the next cycle
// result: a packet-finishing byte waits on two 9-step divides, x then y, on one shared unit,
//         then the clamp and update state loads the word once the output is free
// throughput: one word at a time; req_stall stays high while the divider runs
// reset: synchronous active high; cursor at 400,300, buttons and scroll 0, sensitivity 2,
//        screen 800x600, three-byte packets
`include "ps2_mouse_packet_cursor_tracker_core_assert.svh"
module ps2_mouse_packet_cursor_tracker_core (
   input  logic              clock,
   input  logic              reset,
   // input words
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [7:0]        req_port_status,
   input  logic [7:0]        req_rx_byte,
   // result words
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [11:0]       rsp_cursor_x_out,
   output logic [11:0]       rsp_cursor_y_out,
   output logic [2:0]        rsp_buttons_out,
   output logic signed [7:0] rsp_scroll_out,
   output logic              rsp_packet_done,
   output logic signed [7:0] rsp_scroll_taken,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [12:0]       csr_wdata
);

   // sign-magnitude form of a 9-bit movement offset
   function automatic logic [8:0] offset_mag(input logic [7:0] low8, input logic neg);
      logic [8:0] m;
      m = neg ? 9'(9'd256 - {1'b0, low8}) : {1'b0, low8};
      return m;
   endfunction

   // zero and oversize screen dimensions collapse to 1 and 4096
   function automatic logic [11:0] clamp_axis(input logic signed [13:0] v,
                                              input logic [12:0] size);
      logic [11:0] lim;
      logic [11:0] r;
      if (size == 13'd0) begin
         lim = 12'd0;
      end else if (size > ps2mct_pkg::SCREEN_MAX) begin
         lim = 12'hFFF;
      end else begin
         lim = 12'(size - 13'd1);
      end
      if (v < 0) begin
         r = 12'd0;
      end else if (v > $signed({2'b00, lim})) begin
         r = lim;
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

   // configuration registers
   logic        wheel_ff;
   logic [7:0]  sens_ff;
   logic [12:0] width_ff;
   logic [12:0] height_ff;

   // block state
   ps2mct_pkg::state_type state_ff, state_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [7:0]  pb0_ff, pb0_in;
   logic [7:0]  pb1_ff, pb1_in;
   logic [7:0]  pb2_ff, pb2_in;
   logic [11:0] pos_x_ff, pos_x_in;
   logic [11:0] pos_y_ff, pos_y_in;
   logic [2:0]  buttons_ff, buttons_in;
   logic [7:0]  pending_ff, pending_in;
   logic [7:0]  shown_ff, shown_in;
   logic signed [9:0] qx_ff, qx_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [11:0] out_x_ff;
   logic [11:0] out_y_ff;
   logic [2:0]  out_buttons_ff;
   logic [7:0]  out_shown_ff;
   logic        out_done_ff;
   logic [7:0]  out_taken_ff;

   logic        load_out;
   logic        done_sel;
   logic [7:0]  taken_sel;
   logic        out_free;
   logic        accept;
   logic        byte_ok;
   logic        complete;
   logic signed [13:0] sum_x;
   logic signed [13:0] sum_y;

   ps2mct_pkg::div_req_type div_req;
   ps2mct_pkg::div_rsp_type div_rsp;

   ps2mct_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // handshakes
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ps2mct_pkg::ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign byte_ok  = req_port_status[ps2mct_pkg::STATUS_FULL_BIT]
                     && req_port_status[ps2mct_pkg::STATUS_AUX_BIT];
   // last byte sits at index 2, or 3 with the wheel; index 3 always finishes
   assign complete = byte_index_ff >= {1'b1, wheel_ff};

   // new position: x moves with the offset, y against it
   assign sum_x = $signed({2'b00, pos_x_ff}) + {{4{qx_ff[9]}}, qx_ff};
   assign sum_y = $signed({2'b00, pos_y_ff}) - {{4{div_rsp.quot[9]}}, div_rsp.quot};

   always_comb begin
      state_in      = state_ff;
      byte_index_in = byte_index_ff;
      pb0_in        = pb0_ff;
      pb1_in        = pb1_ff;
      pb2_in        = pb2_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      buttons_in    = buttons_ff;
      pending_in    = pending_ff;
      shown_in      = shown_ff;
      qx_in         = qx_ff;
      load_out      = 1'b0;
      done_sel      = 1'b0;
      taken_sel     = 8'd0;
      div_req       = '0;
      div_req.divisor = sens_ff;

      case (state_ff)
         ps2mct_pkg::ST_IDLE: begin
            if (accept) begin
               load_out = 1'b1;
               if (req_mode == ps2mct_pkg::MODE_SCROLL_READ) begin
                  taken_sel  = pending_ff;
                  pending_in = 8'd0;
                  shown_in   = 8'd0;
               end else if (byte_ok) begin
                  if (complete) begin
                     // result waits for both divides
                     load_out      = 1'b0;
                     byte_index_in = 2'd0;
                     buttons_in    = pb0_ff[2:0];
                     if (!wheel_ff) begin
                        pb2_in = req_rx_byte;
                     end
                     if (wheel_ff && (req_rx_byte != 8'd0)) begin
                        pending_in = 8'(8'd0 - req_rx_byte);
                        shown_in   = 8'(8'd0 - req_rx_byte);
                     end
                     div_req.start = 1'b1;
                     div_req.neg   = pb0_ff[ps2mct_pkg::HDR_X_SIGN_BIT];
                     div_req.mag   = offset_mag(pb1_ff, pb0_ff[ps2mct_pkg::HDR_X_SIGN_BIT]);
                     state_in      = ps2mct_pkg::ST_DIV_X;
                  end else begin
                     byte_index_in = byte_index_ff + 2'd1;
                     case (byte_index_ff)
                        2'd0:    pb0_in = req_rx_byte;
                        2'd1:    pb1_in = req_rx_byte;
                        default: pb2_in = req_rx_byte;
                     endcase
                  end
               end
            end
         end
         ps2mct_pkg::ST_DIV_X: begin
            if (div_rsp.done) begin
               qx_in         = div_rsp.quot;
               div_req.start = 1'b1;
               div_req.neg   = pb0_ff[ps2mct_pkg::HDR_Y_SIGN_BIT];
               div_req.mag   = offset_mag(pb2_ff, pb0_ff[ps2mct_pkg::HDR_Y_SIGN_BIT]);
               state_in      = ps2mct_pkg::ST_DIV_Y;
            end
         end
         ps2mct_pkg::ST_DIV_Y: begin
            // quotient for y stays in the divider until the update
            if (div_rsp.done) begin
               state_in = ps2mct_pkg::ST_UPDATE;
            end
         end
         ps2mct_pkg::ST_UPDATE: begin
            if (out_free) begin
               pos_x_in = clamp_axis(sum_x, width_ff);
               pos_y_in = clamp_axis(sum_y, height_ff);
               load_out = 1'b1;
               done_sel = 1'b1;
               state_in = ps2mct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ps2mct_pkg::ST_IDLE;
         end
      endcase

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ps2mct_pkg::ST_IDLE;
         byte_index_ff <= 2'd0;
         pos_x_ff      <= ps2mct_pkg::POS_X_RESET;
         pos_y_ff      <= ps2mct_pkg::POS_Y_RESET;
         buttons_ff    <= 3'd0;
         pending_ff    <= 8'd0;
         shown_ff      <= 8'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_index_ff <= byte_index_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         buttons_ff    <= buttons_in;
         pending_ff    <= pending_in;
         shown_ff      <= shown_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // packet bytes, quotient and result word need no reset
   always_ff @(posedge clock) begin
      pb0_ff <= pb0_in;
      pb1_ff <= pb1_in;
      pb2_ff <= pb2_in;
      qx_ff  <= qx_in;
      if (load_out) begin
         out_x_ff       <= pos_x_in;
         out_y_ff       <= pos_y_in;
         out_buttons_ff <= buttons_in;
         out_shown_ff   <= shown_in;
         out_done_ff    <= done_sel;
         out_taken_ff   <= taken_sel;
      end
   end

   // register writes; a zero sensitivity is stored as 1
   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff  <= 1'b0;
         sens_ff   <= ps2mct_pkg::SENS_RESET;
         width_ff  <= ps2mct_pkg::WIDTH_RESET;
         height_ff <= ps2mct_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ps2mct_pkg::CSR_WHEEL_ENABLE:  wheel_ff <= csr_wdata[0];
            ps2mct_pkg::CSR_SENSITIVITY: begin
               sens_ff <= (csr_wdata[7:0] == 8'd0) ? 8'd1 : csr_wdata[7:0];
            end
            ps2mct_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            ps2mct_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cursor_x_out = out_x_ff;
   assign rsp_cursor_y_out = out_y_ff;
   assign rsp_buttons_out  = out_buttons_ff;
   assign rsp_scroll_out   = $signed(out_shown_ff);
   assign rsp_packet_done  = out_done_ff;
   assign rsp_scroll_taken = $signed(out_taken_ff);

   // divider only finishes while the sequencer waits on it
   `ASSERT_IMPLY(a_div_done_state, clock, reset, div_rsp.done,
      (state_ff == ps2mct_pkg::ST_DIV_X) || (state_ff == ps2mct_pkg::ST_DIV_Y))
   // a finishing byte starts the x divide
   `ASSERT_NEXT(a_complete_to_div, clock, reset,
      accept && (req_mode == ps2mct_pkg::MODE_RX_BYTE) && byte_ok && complete,
      state_ff == ps2mct_pkg::ST_DIV_X)
   // the update cycle delivers a packet word
   `ASSERT_NEXT(a_update_loads, clock, reset,
      (state_ff == ps2mct_pkg::ST_UPDATE) && out_free, rsp_valid && rsp_packet_done)
   // a packet word never carries taken scroll
   `ASSERT_IMPLY(a_done_no_taken, clock, reset, rsp_valid && rsp_packet_done,
      rsp_scroll_taken == 8'sd0)

endmodule

### sim/ps2_mouse_packet_cursor_tracker_core_test.sv
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_core_test;

   // run shape
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int HOLD_CYCLES     = 200;
   localparam int SETTLE_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int MAX_SHOWN       = 10;

   // one result word as the block reports it
   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [2:0]  buttons;
      logic [7:0]  scroll;
      logic        done;
      logic [7:0]  taken;
   } mouse_report_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // one line of the directed table: an input word or a register write
   typedef struct packed {
      row_kind_type     kind;
      logic             typed;
      logic             mode;
      logic [7:0]       status;
      logic [7:0]       data;
      logic [3:0]       index;
      logic [12:0]      wdata;
      mouse_report_type want;
   } stim_row_type;

   localparam mouse_report_type AT_RESET = '{x: ps2mct_pkg::POS_X_RESET,
                                             y: ps2mct_pkg::POS_Y_RESET, buttons: 3'd0,
                                             scroll: 8'd0, done: 1'b0, taken: 8'd0};
   localparam mouse_report_type FIRST_PACKET = '{x: ps2mct_pkg::POS_X_RESET,
                                                 y: ps2mct_pkg::POS_Y_RESET, buttons: 3'd7,
                                                 scroll: 8'd0, done: 1'b1, taken: 8'd0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = ps2mct_pkg::MODE_RX_BYTE;
   logic [7:0]        req_port_status = 8'd0;
   logic [7:0]        req_rx_byte = 8'd0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [11:0]       rsp_cursor_x_out;
   logic [11:0]       rsp_cursor_y_out;
   logic [2:0]        rsp_buttons_out;
   logic signed [7:0] rsp_scroll_out;
   logic              rsp_packet_done;
   logic signed [7:0] rsp_scroll_taken;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [3:0]        csr_index = ps2mct_pkg::CSR_WHEEL_ENABLE;
   logic [12:0]       csr_wdata = 13'd0;

   // tracker state mirrored by the predictor
   logic        trk_wheel   = 1'b0;
   logic [7:0]  trk_sens    = ps2mct_pkg::SENS_RESET;
   logic [12:0] trk_width   = ps2mct_pkg::WIDTH_RESET;
   logic [12:0] trk_height  = ps2mct_pkg::HEIGHT_RESET;
   logic [1:0]  trk_index   = 2'd0;
   logic [7:0]  trk_bytes [0:2] = '{8'd0, 8'd0, 8'd0};
   int          trk_x       = ps2mct_pkg::POS_X_RESET;
   int          trk_y       = ps2mct_pkg::POS_Y_RESET;
   logic [2:0]  trk_buttons = 3'd0;
   logic [7:0]  trk_pending = 8'd0;
   logic [7:0]  trk_shown   = 8'd0;

   // reports still owed by the block, oldest first
   mouse_report_type report_q [$];
   stim_row_type     directed_rows [$];

   int   error_count  = 0;
   int   quiet_cycles = 0;
   logic idle_on      = 1'b1;
   logic hold_request = 1'b0;

   ps2_mouse_packet_cursor_tracker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_port_status  (req_port_status),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_x_out (rsp_cursor_x_out),
      .rsp_cursor_y_out (rsp_cursor_y_out),
      .rsp_buttons_out  (rsp_buttons_out),
      .rsp_scroll_out   (rsp_scroll_out),
      .rsp_packet_done  (rsp_packet_done),
      .rsp_scroll_taken (rsp_scroll_taken),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // cursor limit: size 0 acts as 1, anything past 4096 saturates at 4095
   function automatic int clamp_to_screen(int v, logic [12:0] size);
      int lim;
      if (size == 13'd0) lim = 0;
      else if (size > ps2mct_pkg::SCREEN_MAX) lim = int'(ps2mct_pkg::SCREEN_MAX) - 1;
      else lim = int'(size) - 1;
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v;
   endfunction

   // advance the mirrored tracker by one accepted word and report its state
   function automatic mouse_report_type track_word(logic m, logic [7:0] st, logic [7:0] d);
      mouse_report_type rep;
      logic [1:0]       last;
      logic [7:0]       ybyte;
      int               dx;
      int               dy;
      int               div;
      rep = '0;
      if (m == ps2mct_pkg::MODE_SCROLL_READ) begin
         // hand back pending scroll and clear both copies
         rep.taken = trk_pending;
         trk_pending = 8'd0;
         trk_shown = 8'd0;
      end else if (st[ps2mct_pkg::STATUS_FULL_BIT] && st[ps2mct_pkg::STATUS_AUX_BIT]) begin
         last = trk_wheel ? 2'd3 : 2'd2;
         if (trk_index >= last) begin
            // packet complete; a leftover fourth slot with wheel off is the y byte
            ybyte = trk_wheel ? trk_bytes[2] : d;
            if (!trk_wheel) trk_bytes[2] = d;
            rep.done = 1'b1;
            trk_index = 2'd0;
            trk_buttons = trk_bytes[0][2:0];
            dx = trk_bytes[1];
            if (trk_bytes[0][ps2mct_pkg::HDR_X_SIGN_BIT]) dx = dx - 256;
            dy = ybyte;
            if (trk_bytes[0][ps2mct_pkg::HDR_Y_SIGN_BIT]) dy = dy - 256;
            // wheel byte negated, -128 wraps onto itself
            if (trk_wheel && d != 8'd0) begin
               trk_pending = 8'd0 - d;
               trk_shown = 8'd0 - d;
            end
            div = trk_sens;
            trk_x = clamp_to_screen(trk_x + dx / div, trk_width);
            trk_y = clamp_to_screen(trk_y - dy / div, trk_height);
         end else begin
            trk_bytes[trk_index] = d;
            trk_index = trk_index + 2'd1;
         end
      end
      rep.x = trk_x[11:0];
      rep.y = trk_y[11:0];
      rep.buttons = trk_buttons;
      rep.scroll = trk_shown;
      return rep;
   endfunction

   function automatic stim_row_type word_row(logic m, logic [7:0] st, logic [7:0] d);
      stim_row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.mode = m;
      r.status = st;
      r.data = d;
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic m, logic [7:0] st, logic [7:0] d,
                                              mouse_report_type want);
      stim_row_type r;
      r = word_row(m, st, d);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [3:0] idx, logic [12:0] v);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = idx;
      r.wdata = v;
      return r;
   endfunction

   // screen size pick that walks through the extremes
   function automatic logic [12:0] screen_pick(int k);
      case (k % 5)
         0: return 13'd1;
         1: return ps2mct_pkg::SCREEN_MAX;
         2: return 13'd0;
         3: return 13'd8191;
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
         if (error_count < MAX_SHOWN)
            $display("mismatch on %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
         error_count++;
      end
   endfunction

   // offer one input word, wait for it to be taken, then record what it should produce
   task automatic send_word(input logic m, input logic [7:0] st, input logic [7:0] d,
                            input logic typed = 1'b0, input mouse_report_type want = '0);
      int               gap;
      mouse_report_type rep;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_port_status <= st;
      req_rx_byte <= d;
      do @(posedge clock); while (req_stall);
      rep = track_word(m, st, d);
      report_q.push_back(typed ? want : rep);
   endtask

   // a controller byte with good status, sometimes after an ignored one
   task automatic send_byte(input logic [7:0] d);
      logic [7:0] st;
      if ($urandom_range(0, 9) == 0) begin
         st = 8'($urandom_range(0, 255));
         if (st[ps2mct_pkg::STATUS_FULL_BIT] && st[ps2mct_pkg::STATUS_AUX_BIT]) begin
            if ($urandom_range(0, 1) == 0) st[ps2mct_pkg::STATUS_FULL_BIT] = 1'b0;
            else st[ps2mct_pkg::STATUS_AUX_BIT] = 1'b0;
         end
         send_word(ps2mct_pkg::MODE_RX_BYTE, st, 8'($urandom_range(0, 255)));
      end
      st = 8'($urandom_range(0, 255)) | 8'h21;
      send_word(ps2mct_pkg::MODE_RX_BYTE, st, d);
   endtask

   // register write; csr_valid is left high so back to back writes need no lowering
   task automatic write_register(input logic [3:0] idx, input logic [12:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ps2mct_pkg::CSR_WHEEL_ENABLE:  trk_wheel = v[0];
         ps2mct_pkg::CSR_SENSITIVITY:   trk_sens = (v[7:0] == 8'd0) ? 8'd1 : v[7:0];
         ps2mct_pkg::CSR_SCREEN_WIDTH:  trk_width = v;
         ps2mct_pkg::CSR_SCREEN_HEIGHT: trk_height = v;
         default: ;
      endcase
   endtask

   // stop offering and let every owed report come back
   task automatic drain();
      req_valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
   endtask

   // result side: random stall per word, plus one long hold when asked
   initial begin
      int stall_gap;
      while (reset) @(posedge clock);
      forever begin
         stall_gap = idle_on ? $urandom_range(0, 6) : 0;
         if (hold_request) begin
            stall_gap = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall_gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each taken result word with the oldest owed report
   always @(posedge clock) begin
      mouse_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (report_q.size() == 0) begin
            if (error_count < MAX_SHOWN)
               $display("unexpected result word at %0t", $realtime);
            error_count++;
         end else begin
            want = report_q.pop_front();
            check_field("cursor_x_out", want.x, rsp_cursor_x_out);
            check_field("cursor_y_out", want.y, rsp_cursor_y_out);
            check_field("buttons_out", 12'(want.buttons), 12'(rsp_buttons_out));
            check_field("scroll_out", 12'(want.scroll), {4'd0, rsp_scroll_out});
            check_field("packet_done", 12'(want.done), 12'(rsp_packet_done));
            check_field("scroll_taken", 12'(want.taken), {4'd0, rsp_scroll_taken});
         end
      end
   end

   // watchdog: too long with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** ps2_mouse_packet_cursor_tracker_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      logic [12:0]  wd;
      logic [7:0]   hdr;
      logic         drift;
      int           counted;
      int           pick;

      // directed table, three-byte packets at reset settings first
      directed_rows.push_back(typed_row(ps2mct_pkg::MODE_SCROLL_READ, 8'h00, 8'h00, AT_RESET));
      // status lacking aux bit, then lacking output-full bit: ignored
      directed_rows.push_back(typed_row(ps2mct_pkg::MODE_RX_BYTE, 8'h01, 8'hFF, AT_RESET));
      directed_rows.push_back(typed_row(ps2mct_pkg::MODE_RX_BYTE, 8'h20, 8'h55, AT_RESET));
      directed_rows.push_back(typed_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h07, AT_RESET));
      directed_rows.push_back(typed_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h00, AT_RESET));
      directed_rows.push_back(typed_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h00,
                                        FIRST_PACKET));
      // both offsets at -256
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'hFF, 8'h30));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'hFF, 8'h00));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'hFF, 8'h00));
      // wheel packets, full-resolution screen, no division
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_WHEEL_ENABLE, 13'd1));
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_SENSITIVITY, 13'd1));
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_SCREEN_WIDTH, ps2mct_pkg::SCREEN_MAX));
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_SCREEN_HEIGHT, ps2mct_pkg::SCREEN_MAX));
      // wheel byte -128 stays -128
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h08));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h7F));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h80));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h80));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_SCROLL_READ, 8'hFF, 8'hFF));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h01));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h00));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h00));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h01));
      // three bytes gathered in wheel mode, then wheel off: next byte closes it as y
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h02));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h10));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h10));
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_WHEEL_ENABLE, 13'd0));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h05));
      // zero screen size; sensitivity low byte zero is stored as 1
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_SCREEN_WIDTH, 13'd0));
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_SCREEN_HEIGHT, 13'd0));
      directed_rows.push_back(csr_row(ps2mct_pkg::CSR_SENSITIVITY, 13'd256));
      // position stays off screen until the next packet
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_SCROLL_READ, 8'h00, 8'h00));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h00));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h01));
      directed_rows.push_back(word_row(ps2mct_pkg::MODE_RX_BYTE, 8'h21, 8'h01));

      // reset held from the start, released on an edge
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (int i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            drain();
            write_register(row.index, row.wdata);
            if (i + 1 == directed_rows.size() || directed_rows[i + 1].kind != ROW_CSR)
               csr_valid <= 1'b0;
         end else begin
            send_word(row.mode, row.status, row.data, row.typed, row.want);
         end
      end

      // random phases, each with its own register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         // sender pauses until every owed report is back
         drain();
         wd = 13'($urandom_range(0, 8191));
         wd[0] = phase[0];
         write_register(ps2mct_pkg::CSR_WHEEL_ENABLE, wd);
         case (phase % 6)
            0: wd = 13'd1;
            1: wd = 13'd255;
            2: wd = 13'd0;
            3: wd = 13'd2;
            4: wd = 13'($urandom_range(1, 8));
            default: wd = 13'($urandom_range(0, 8191));
         endcase
         write_register(ps2mct_pkg::CSR_SENSITIVITY, wd);
         write_register(ps2mct_pkg::CSR_SCREEN_WIDTH, screen_pick(phase));
         write_register(ps2mct_pkg::CSR_SCREEN_HEIGHT, screen_pick(phase + 2));
         csr_valid <= 1'b0;

         // every third phase runs with no idling on either side
         idle_on = (phase % 3 != 2);
         // one phase stalls the result side long enough to back up the input
         if (phase == 3) hold_request = 1'b1;
         drift = 1'($urandom_range(0, 1));
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_word(ps2mct_pkg::MODE_SCROLL_READ, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
               counted++;
            end else if (pick < 14) begin
               // stray byte that shifts packet framing
               send_byte(8'($urandom_range(0, 255)));
               counted++;
            end else begin
               // well-formed packet, offsets biased so the cursor reaches the edges
               hdr = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 3) != 0) begin
                  hdr[ps2mct_pkg::HDR_X_SIGN_BIT] = drift;
                  hdr[ps2mct_pkg::HDR_Y_SIGN_BIT] = !drift;
               end
               send_byte(hdr);
               send_byte(8'($urandom_range(0, 255)));
               send_byte(8'($urandom_range(0, 255)));
               counted += 3;
               if (trk_wheel) begin
                  send_byte(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
                  counted++;
               end
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("** ps2_mouse_packet_cursor_tracker_core: PASSED **");
      else
         $display("** ps2_mouse_packet_cursor_tracker_core: FAILED **");
      $finish;
   end

endmodule
